// ===== rtl/core/node_table_min_score_select_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef NODE_TABLE_MIN_SCORE_SELECT_UNIT_ASSERT_SVH
`define NODE_TABLE_MIN_SCORE_SELECT_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define NTMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NTMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ntms_pkg.sv =====
// ----------------------------------------------------------------------------
// ntms_pkg
// Types and constants of the node table min score select unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ntms_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int ID_W       = 32;
    localparam int LEVEL_W    = 32;
    localparam int SCORE_W    = 37;

    localparam int W_LOAD   = 4;
    localparam int W_MEMORY = 3;
    localparam int W_ACCEL  = 5;
    localparam int W_LINK   = 2;

    localparam logic [1:0] MODE_UPSERT = 2'd0;
    localparam logic [1:0] MODE_SELECT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BAD_ID = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ID_W-1:0]    node_id;
        logic               reachable;
        logic               quarantined;
        logic [LEVEL_W-1:0] load_level;
        logic [LEVEL_W-1:0] memory_level;
        logic [LEVEL_W-1:0] accel_level;
        logic [LEVEL_W-1:0] link_level;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [ID_W-1:0]    target_id;
        logic [SCORE_W-1:0] target_score;
    } t_rsp;

    // one table entry as kept in memory
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               reachable;
        logic               quarantined;
        logic [LEVEL_W-1:0] load;
        logic [LEVEL_W-1:0] memory;
        logic [LEVEL_W-1:0] accel;
        logic [LEVEL_W-1:0] link;
    } t_entry;

    // read issued last cycle, aligned with the memory read data
    typedef struct packed {
        logic            vld;
        logic            last;
        logic            used;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0] node_id;
    } t_rd;

    // scored entry handed back to the sequencer
    typedef struct packed {
        logic               vld;
        logic               last;
        logic               ok;
        logic               match;
        logic [IDX_W-1:0]   idx;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_cand;

endpackage

`default_nettype wire

// ===== rtl/core/ntms_table_ram.sv =====
// ----------------------------------------------------------------------------
// ntms_table_ram
// Node table storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ntms_table_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [ntms_pkg::IDX_W-1:0] i_waddr,
    input  wire ntms_pkg::t_entry           i_wdata,
    input  wire logic [ntms_pkg::IDX_W-1:0] i_raddr,
    output ntms_pkg::t_entry                o_rdata
);

    ntms_pkg::t_entry r_mem [ntms_pkg::TABLE_SIZE];
    ntms_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/ntms_score.sv =====
// ----------------------------------------------------------------------------
// ntms_score
// Scores one entry read from the table and flags eligibility and id match.
// ----------------------------------------------------------------------------
`default_nettype none

module ntms_score (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ntms_pkg::t_rd    i_rd,
    input  wire ntms_pkg::t_entry i_entry,
    output ntms_pkg::t_cand       o_cand
);

    ntms_pkg::t_cand r_cand;
    ntms_pkg::t_cand n_cand;

    always_comb begin
        n_cand.vld   = i_rd.vld;
        n_cand.last  = i_rd.last;
        n_cand.idx   = i_rd.idx;
        n_cand.id    = i_entry.id;
        // zero id never sits in a used entry, so excluding zero excludes nothing
        n_cand.ok    = i_rd.used && (i_entry.id != i_rd.node_id) &&
                       i_entry.reachable && !i_entry.quarantined;
        n_cand.match = i_rd.used && (i_entry.id == i_rd.node_id);
        n_cand.score =
            ntms_pkg::SCORE_W'(i_entry.load)   * ntms_pkg::SCORE_W'(ntms_pkg::W_LOAD) +
            ntms_pkg::SCORE_W'(i_entry.memory) * ntms_pkg::SCORE_W'(ntms_pkg::W_MEMORY) +
            ntms_pkg::SCORE_W'(i_entry.accel)  * ntms_pkg::SCORE_W'(ntms_pkg::W_ACCEL) +
            ntms_pkg::SCORE_W'(i_entry.link)   * ntms_pkg::SCORE_W'(ntms_pkg::W_LINK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.vld <= 1'b0;
        end else begin
            r_cand.vld <= n_cand.vld;
        end
        r_cand.last  <= n_cand.last;
        r_cand.ok    <= n_cand.ok;
        r_cand.match <= n_cand.match;
        r_cand.idx   <= n_cand.idx;
        r_cand.id    <= n_cand.id;
        r_cand.score <= n_cand.score;
    end

    assign o_cand = r_cand;

endmodule

`default_nettype wire

// ===== rtl/core/ntms_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntms_ctrl
// Request sequencer: scans the table, tracks best candidate, match and free
// slot, writes back upserts and builds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module ntms_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    input  wire ntms_pkg::t_req             i_req,
    output logic                            o_req_ready,
    output logic                            o_we,
    output logic [ntms_pkg::IDX_W-1:0]      o_waddr,
    output ntms_pkg::t_entry                o_wdata,
    output logic [ntms_pkg::IDX_W-1:0]      o_raddr,
    output ntms_pkg::t_rd                   o_rd,
    input  wire ntms_pkg::t_cand            i_cand,
    input  wire logic                       i_res_free,
    output logic                            o_res_vld,
    output ntms_pkg::t_rsp                  o_res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    localparam logic [ntms_pkg::IDX_W-1:0] LAST_IDX =
        ntms_pkg::IDX_W'(ntms_pkg::TABLE_SIZE - 1);

    logic [1:0]                       r_state,  n_state;
    ntms_pkg::t_req                   r_req,    n_req;
    logic [ntms_pkg::TABLE_SIZE-1:0]  r_used,   n_used;
    logic [ntms_pkg::IDX_W-1:0]       r_addr,   n_addr;
    ntms_pkg::t_rd                    r_rd,     n_rd;
    logic                             r_have,   n_have;
    logic [ntms_pkg::SCORE_W-1:0]     r_best_score, n_best_score;
    logic [ntms_pkg::ID_W-1:0]        r_best_id,    n_best_id;
    logic                             r_match_hit,  n_match_hit;
    logic [ntms_pkg::IDX_W-1:0]       r_match_idx,  n_match_idx;
    logic                             r_free_hit,   n_free_hit;
    logic [ntms_pkg::IDX_W-1:0]       r_free_idx,   n_free_idx;

    logic fire;
    logic better;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_used       = r_used;
        n_addr       = r_addr;
        n_have       = r_have;
        n_best_score = r_best_score;
        n_best_id    = r_best_id;
        n_match_hit  = r_match_hit;
        n_match_idx  = r_match_idx;
        n_free_hit   = r_free_hit;
        n_free_idx   = r_free_idx;
        o_we         = 1'b0;
        o_waddr      = r_free_idx;
        o_res        = '0;
        fire         = 1'b0;

        n_rd.vld     = (r_state == ST_SCAN);
        n_rd.last    = (r_addr == LAST_IDX);
        n_rd.used    = r_used[r_addr];
        n_rd.idx     = r_addr;
        n_rd.node_id = r_req.node_id;

        // candidates come back through the registered memory read and the score register
        better = !r_have || (i_cand.score < r_best_score) ||
                 ((i_cand.score == r_best_score) && (i_cand.id < r_best_id));
        if (i_cand.vld) begin
            if (i_cand.match && !r_match_hit) begin
                n_match_hit = 1'b1;
                n_match_idx = i_cand.idx;
            end
            if (i_cand.ok && better) begin
                n_have       = 1'b1;
                n_best_score = i_cand.score;
                n_best_id    = i_cand.id;
            end
        end

        // response, posted from the final state once the output register is free
        case (r_req.mode)
            ntms_pkg::MODE_UPSERT: begin
                if (r_req.node_id == '0) begin
                    o_res.status = ntms_pkg::STATUS_BAD_ID;
                end else if (!r_match_hit && !r_free_hit) begin
                    o_res.status = ntms_pkg::STATUS_FULL;
                end
            end
            ntms_pkg::MODE_SELECT: begin
                if (r_have) begin
                    o_res.found        = 1'b1;
                    o_res.target_id    = r_best_id;
                    o_res.target_score = r_best_score;
                end
            end
            default: begin
            end
        endcase

        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_req       = i_req;
                    n_addr      = '0;
                    n_have      = 1'b0;
                    n_match_hit = 1'b0;
                    n_free_hit  = 1'b0;
                    if ((i_req.mode == ntms_pkg::MODE_UPSERT && i_req.node_id != '0) ||
                        i_req.mode == ntms_pkg::MODE_SELECT) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + ntms_pkg::IDX_W'(1);
                // lowest free slot straight from the used bits
                if (!r_used[r_addr] && !r_free_hit) begin
                    n_free_hit = 1'b1;
                    n_free_idx = r_addr;
                end
                if (r_addr == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_cand.vld && i_cand.last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_res_free) begin
                    fire    = 1'b1;
                    n_state = ST_IDLE;
                    if (r_req.mode == ntms_pkg::MODE_CLEAR) begin
                        n_used = '0;
                    end else if (r_req.mode == ntms_pkg::MODE_UPSERT &&
                                 r_req.node_id != '0 &&
                                 (r_match_hit || r_free_hit)) begin
                        o_we    = 1'b1;
                        o_waddr = r_match_hit ? r_match_idx : r_free_idx;
                        n_used[o_waddr] = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_rd.vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_rd.vld <= n_rd.vld;
        end
        r_req        <= n_req;
        r_addr       <= n_addr;
        r_rd.last    <= n_rd.last;
        r_rd.used    <= n_rd.used;
        r_rd.idx     <= n_rd.idx;
        r_rd.node_id <= n_rd.node_id;
        r_have       <= n_have;
        r_best_score <= n_best_score;
        r_best_id    <= n_best_id;
        r_match_hit  <= n_match_hit;
        r_match_idx  <= n_match_idx;
        r_free_hit   <= n_free_hit;
        r_free_idx   <= n_free_idx;
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_raddr     = r_addr;
    assign o_rd        = r_rd;
    assign o_res_vld   = fire;

    assign o_wdata.id          = r_req.node_id;
    assign o_wdata.reachable   = r_req.reachable;
    assign o_wdata.quarantined = r_req.quarantined;
    assign o_wdata.load        = r_req.load_level;
    assign o_wdata.memory      = r_req.memory_level;
    assign o_wdata.accel       = r_req.accel_level;
    assign o_wdata.link        = r_req.link_level;

endmodule

`default_nettype wire

// ===== rtl/core/node_table_min_score_select_unit.sv =====
// ----------------------------------------------------------------------------
// node_table_min_score_select_unit
// Node health table with upsert, min-score select and clear.
// ----------------------------------------------------------------------------
// One request is worked at a time. Upsert (nonzero id) and select walk the
// whole table through the single read port of the entry memory, one entry per
// cycle, followed by a two-stage read and score pipeline, a drain state and a
// final state that writes back and posts the response. Clear, upsert of id
// zero and the unused mode go straight to the final state. A response sits
// in an output register, so the next request is accepted while the previous
// response waits; a request whose response is done only stalls if the output
// register is still full.
`default_nettype none

module node_table_min_score_select_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire ntms_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_ready,
    output ntms_pkg::t_rsp      o_rsp
);

    logic                       we;
    logic [ntms_pkg::IDX_W-1:0] waddr;
    logic [ntms_pkg::IDX_W-1:0] raddr;
    ntms_pkg::t_entry           wdata;
    ntms_pkg::t_entry           rdata;
    ntms_pkg::t_rd              rd;
    ntms_pkg::t_cand            cand;
    logic                       res_vld;
    ntms_pkg::t_rsp             res;
    logic                       res_free;

    logic           r_out_vld;
    ntms_pkg::t_rsp r_out;

    ntms_table_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ntms_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_entry (rdata),
        .o_cand  (cand)
    );

    ntms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_ready (o_req_ready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .o_rd        (rd),
        .i_cand      (cand),
        .i_res_free  (res_free),
        .o_res_vld   (res_vld),
        .o_res       (res)
    );

    assign res_free = !r_out_vld || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
        if (res_vld) begin
            r_out <= res;
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/ntms_checker.sv =====
// ----------------------------------------------------------------------------
// ntms_checker
// Port-level checks of the node table unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "node_table_min_score_select_unit_assert.svh"

module ntms_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           o_req_ready,
    input wire logic           o_rsp_valid,
    input wire logic           i_rsp_ready,
    input wire ntms_pkg::t_rsp o_rsp
);

    // a stalled response holds
    `NTMS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && !i_rsp_ready, o_rsp_valid && $stable(o_rsp), "stalled response changed")

    // one request at a time: ready drops right after an accepted request
    `NTMS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && o_req_ready, !o_req_ready, "ready held after request")

    // a found target has a nonzero id and ok status
    `NTMS_ASSERT_NOW(a_found_ok, i_clk, i_rst_n, o_rsp_valid && o_rsp.found, o_rsp.status == ntms_pkg::STATUS_OK && o_rsp.target_id != '0, "found target malformed")

    // no target means zero id and score
    `NTMS_ASSERT_NOW(a_none_zero, i_clk, i_rst_n, o_rsp_valid && !o_rsp.found, o_rsp.target_id == '0 && o_rsp.target_score == '0, "empty target not zero")

endmodule

bind node_table_min_score_select_unit ntms_checker u_ntms_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the node table min score select unit against a cycle-free table
// model: requests are offered from a queue under varying sender and receiver
// idling, and every response is compared field by field with the prediction.
// ----------------------------------------------------------------------------

module testbench;

    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         ID_POOL_N   = 20;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic req_valid   = 1'b0;
    ntms_pkg::t_req req_bits = '0;
    logic rsp_ready   = 1'b0;
    logic o_req_ready;
    logic o_rsp_valid;
    ntms_pkg::t_rsp o_rsp;

    node_table_min_score_select_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (req_bits),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (o_rsp)
    );

    // shadow copy of the node table
    logic             tbl_used  [ntms_pkg::TABLE_SIZE];
    ntms_pkg::t_entry tbl_entry [ntms_pkg::TABLE_SIZE];

    ntms_pkg::t_req req_q[$];
    ntms_pkg::t_rsp predicted_rsp_q[$];

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_arm      = 1'b0;
    int   hold_left     = 0;
    int   fail_count    = 0;

    logic [ntms_pkg::ID_W-1:0] id_pool [ID_POOL_N];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic ntms_pkg::t_rsp table_apply(ntms_pkg::t_req r);
        ntms_pkg::t_rsp            res;
        int                        slot;
        logic                      have;
        logic [63:0]               s;
        logic [63:0]               best;
        logic [ntms_pkg::ID_W-1:0] best_id;
        res     = '0;
        slot    = -1;
        have    = 1'b0;
        best    = '0;
        best_id = '0;
        case (r.mode)
            ntms_pkg::MODE_UPSERT: begin
                if (r.node_id == '0) begin
                    res.status = ntms_pkg::STATUS_BAD_ID;
                end else begin
                    for (int i = 0; i < ntms_pkg::TABLE_SIZE; i++) begin
                        if (slot < 0 && tbl_used[i] && tbl_entry[i].id == r.node_id) slot = i;
                    end
                    for (int i = 0; i < ntms_pkg::TABLE_SIZE; i++) begin
                        if (slot < 0 && !tbl_used[i]) slot = i;
                    end
                    if (slot < 0) begin
                        res.status = ntms_pkg::STATUS_FULL;
                    end else begin
                        tbl_used[slot]              = 1'b1;
                        tbl_entry[slot].id          = r.node_id;
                        tbl_entry[slot].reachable   = r.reachable;
                        tbl_entry[slot].quarantined = r.quarantined;
                        tbl_entry[slot].load        = r.load_level;
                        tbl_entry[slot].memory      = r.memory_level;
                        tbl_entry[slot].accel       = r.accel_level;
                        tbl_entry[slot].link        = r.link_level;
                    end
                end
            end
            ntms_pkg::MODE_SELECT: begin
                for (int i = 0; i < ntms_pkg::TABLE_SIZE; i++) begin
                    if (tbl_used[i] && tbl_entry[i].id != r.node_id
                            && tbl_entry[i].reachable && !tbl_entry[i].quarantined) begin
                        s = {32'd0, tbl_entry[i].load}   * 64'd4
                          + {32'd0, tbl_entry[i].memory} * 64'd3
                          + {32'd0, tbl_entry[i].accel}  * 64'd5
                          + {32'd0, tbl_entry[i].link}   * 64'd2;
                        if (!have || s < best || (s == best && tbl_entry[i].id < best_id)) begin
                            have    = 1'b1;
                            best    = s;
                            best_id = tbl_entry[i].id;
                        end
                    end
                end
                if (have) begin
                    res.found        = 1'b1;
                    res.target_id    = best_id;
                    res.target_score = best[ntms_pkg::SCORE_W-1:0];
                end
            end
            ntms_pkg::MODE_CLEAR: begin
                for (int i = 0; i < ntms_pkg::TABLE_SIZE; i++) begin
                    tbl_used[i]  = 1'b0;
                    tbl_entry[i] = '0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        logic took;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            took = req_valid && o_req_ready;
            if (took) predicted_rsp_q.push_back(table_apply(req_bits));
            if (!req_valid || took) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_bits  <= req_q.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        ntms_pkg::t_rsp want;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (o_rsp_valid && rsp_ready) begin
                if (predicted_rsp_q.size() == 0) begin
                    $error("response with no request outstanding");
                    fail_count = fail_count + 1;
                end else begin
                    want = predicted_rsp_q.pop_front();
                    if (o_rsp.status !== want.status) begin
                        $error("status expected %0h got %0h", want.status, o_rsp.status);
                        fail_count = fail_count + 1;
                    end
                    if (o_rsp.found !== want.found) begin
                        $error("found expected %0h got %0h", want.found, o_rsp.found);
                        fail_count = fail_count + 1;
                    end
                    if (o_rsp.target_id !== want.target_id) begin
                        $error("target_id expected %0h got %0h", want.target_id,
                               o_rsp.target_id);
                        fail_count = fail_count + 1;
                    end
                    if (o_rsp.target_score !== want.target_score) begin
                        $error("target_score expected %0h got %0h", want.target_score,
                               o_rsp.target_score);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (hold_arm || hold_left != 0) begin
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic push_upsert(input logic [ntms_pkg::ID_W-1:0] id, input logic reach,
                               input logic quar,
                               input logic [ntms_pkg::LEVEL_W-1:0] ld,
                               input logic [ntms_pkg::LEVEL_W-1:0] mem,
                               input logic [ntms_pkg::LEVEL_W-1:0] acc,
                               input logic [ntms_pkg::LEVEL_W-1:0] lnk);
        ntms_pkg::t_req r;
        r              = '0;
        r.mode         = ntms_pkg::MODE_UPSERT;
        r.node_id      = id;
        r.reachable    = reach;
        r.quarantined  = quar;
        r.load_level   = ld;
        r.memory_level = mem;
        r.accel_level  = acc;
        r.link_level   = lnk;
        req_q.push_back(r);
    endtask

    task automatic push_op(input logic [1:0] mode, input logic [ntms_pkg::ID_W-1:0] id);
        ntms_pkg::t_req r;
        r         = '0;
        r.mode    = mode;
        r.node_id = id;
        req_q.push_back(r);
    endtask

    // extremes, tiny values for score ties, or anything
    function automatic logic [ntms_pkg::LEVEL_W-1:0] rand_level();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? '1 : '0;
            1:       return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ntms_pkg::ID_W-1:0] rand_id();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return '0;
        if (pick < 70) return id_pool[$urandom_range(ID_POOL_N - 1)];
        return $urandom;
    endfunction

    task automatic queue_random(input int n);
        ntms_pkg::t_req r;
        int             pick;
        for (int k = 0; k < n; k++) begin
            r.node_id      = rand_id();
            r.reachable    = ($urandom_range(99) < 80);
            r.quarantined  = ($urandom_range(99) < 20);
            r.load_level   = rand_level();
            r.memory_level = rand_level();
            r.accel_level  = rand_level();
            r.link_level   = rand_level();
            pick = $urandom_range(99);
            if (pick < 52) r.mode = ntms_pkg::MODE_UPSERT;
            else if (pick < 95) r.mode = ntms_pkg::MODE_SELECT;
            else if (pick < 98) r.mode = ntms_pkg::MODE_CLEAR;
            else r.mode = MODE_NONE;
            req_q.push_back(r);
        end
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (req_q.size() != 0 || req_valid || predicted_rsp_q.size() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int stall);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = stall;
    endtask

    initial begin
        for (int i = 0; i < ntms_pkg::TABLE_SIZE; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_entry[i] = '0;
        end
        id_pool[0] = 32'd1;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL_N; i++) begin
            id_pool[i] = $urandom;
            if (id_pool[i] == '0) id_pool[i] = 32'd3;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        set_idling(0, 0);
        push_op(ntms_pkg::MODE_SELECT, '0);
        push_upsert('0, 1'b1, 1'b0, 32'd5, 32'd5, 32'd5, 32'd5);
        push_op(MODE_NONE, '1);
        push_upsert('1, 1'b1, 1'b0, '1, '1, '1, '1);
        push_upsert(32'd1, 1'b1, 1'b0, '0, '0, '0, '0);
        push_op(ntms_pkg::MODE_SELECT, '0);
        push_op(ntms_pkg::MODE_SELECT, 32'd1);
        push_upsert(32'd1, 1'b0, 1'b0, '0, '0, '0, '0);
        push_upsert(32'd2, 1'b1, 1'b1, '0, '0, '0, '0);
        // equal scores, the smaller id wins
        push_upsert(32'd7, 1'b1, 1'b0, 32'd1, '0, '0, '0);
        push_upsert(32'd5, 1'b1, 1'b0, '0, '0, '0, 32'd2);
        push_op(ntms_pkg::MODE_SELECT, '0);
        // fill the table up
        for (int i = 0; i < 11; i++) begin
            push_upsert(32'd100 + i, 1'b1, 1'b0, $urandom, $urandom, $urandom, $urandom);
        end
        push_upsert(32'd200, 1'b1, 1'b0, '0, '0, '0, '0);
        push_upsert(32'd100, 1'b1, 1'b0, '0, '0, '0, '0);
        push_op(ntms_pkg::MODE_SELECT, 32'd100);
        push_op(ntms_pkg::MODE_CLEAR, '0);
        push_op(ntms_pkg::MODE_SELECT, '0);
        drain();

        set_idling(0, 0);
        queue_random(150);
        drain();

        set_idling(62, 0);
        queue_random(150);
        drain();

        set_idling(0, 62);
        queue_random(150);
        drain();

        set_idling(37, 37);
        queue_random(150);
        drain();

        // receiver holds off while requests keep coming
        set_idling(0, 0);
        queue_random(40);
        hold_arm = 1'b1;
        @(negedge i_clk);
        hold_arm = 1'b0;
        drain();

        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
